// ===== rtl/assert_macros.svh =====
// assertion macros used by the port checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked outside reset
`define ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication checked outside reset
`define ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// property checked at every edge, reset included
`define ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk) (prop)) \
    else $error("check failed");

`endif

// ===== rtl/kpec_pkg.sv =====
// types and constants of the key press event classifier
package kpec_pkg;

  localparam int unsigned SHORT_W = 8;
  localparam int unsigned TICK_W  = 9;
  localparam int unsigned KEY_W   = 8;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned REL_W   = 12;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [REL_W-1:0] UP_DONE = 12'hFFF;

  localparam logic [KEY_W-1:0] KEY_NONE_LO = 8'h00;
  localparam logic [KEY_W-1:0] KEY_NONE_HI = 8'hFF;

  localparam logic [SHORT_W-1:0] SHORT_RESET     = 8'd8;
  localparam logic [TICK_W-1:0]  LONG_RESET      = 9'd200;
  localparam logic [TICK_W-1:0]  REPEAT_RESET    = 9'd220;
  localparam logic [TICK_W-1:0]  REL_START_RESET = 9'd16;
  localparam logic [TICK_W-1:0]  REL_END_RESET   = 9'd19;

  typedef enum logic [KIND_W-1:0] {
    KIND_SHORT_DOWN = 3'd0,
    KIND_LONG_DOWN  = 3'd1,
    KIND_HOLD       = 3'd2,
    KIND_SHORT_UP   = 3'd3,
    KIND_LONG_UP    = 3'd4
  } event_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHORT     = 3'd0,
    REG_LONG      = 3'd1,
    REG_REPEAT    = 3'd2,
    REG_REL_START = 3'd3,
    REG_REL_END   = 3'd4
  } cfg_reg_t;

endpackage

// ===== rtl/key_press_event_classifier_unit.sv =====
// key press event classifier top level
//
// input channel: one scan tick per transfer on in_valid / in_stall, carrying
// key_sample; codes 0 and 255 mean no key is down
// output channel: out_valid / out_stall carry event_kind and event_key; a tick
// gives at most one event, most ticks give none
// configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high; the user must make writes only while no ticks are in flight,
// which the block itself does not enforce; a tick taken lands in the input
// register, and its event moves on to the result register once that can advance
// throughput: one tick per cycle while the output is not stalled, set by the
// single pass from the input register through the counter update to the result
// register; when the output is stalled while holding an event, the input
// register holds its tick and raises in_stall only once it is occupied
// reset clears both counters, the latch, the remembered keys and both
// registers' valid flags, and loads the default thresholds
module key_press_event_classifier_unit #(
  parameter int unsigned COUNT_LIMIT = 500
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [kpec_pkg::KEY_W-1:0]     key_sample,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [kpec_pkg::KIND_W-1:0]    event_kind,
  output logic [kpec_pkg::KEY_W-1:0]     event_key,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [kpec_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kpec_pkg::TICK_W-1:0]    cfg_data
);

  localparam int unsigned LIM_W = $clog2(COUNT_LIMIT + 1);
  localparam int unsigned PW = (LIM_W > kpec_pkg::TICK_W) ? LIM_W : kpec_pkg::TICK_W;
  localparam int unsigned RW = kpec_pkg::REL_W;

  // configuration registers
  logic [kpec_pkg::SHORT_W-1:0] short_ticks;
  logic [kpec_pkg::TICK_W-1:0]  long_ticks;
  logic [kpec_pkg::TICK_W-1:0]  repeat_ticks;
  logic [kpec_pkg::TICK_W-1:0]  release_start;
  logic [kpec_pkg::TICK_W-1:0]  release_end;

  // state
  logic [PW-1:0]              press_count, press_count_next;
  logic [RW-1:0]              release_count, release_count_next;
  logic                       press_latched, press_latched_next;
  logic [kpec_pkg::KEY_W-1:0] previous_sample, previous_sample_next;
  logic [kpec_pkg::KEY_W-1:0] remembered_key, remembered_key_next;

  // input and result registers
  logic                       stage_valid;
  logic [kpec_pkg::KEY_W-1:0] stage_sample;
  logic                       advance;
  logic                       emit;
  kpec_pkg::event_kind_t      kind;
  logic [kpec_pkg::KEY_W-1:0] key;

  logic          released;
  logic          early;
  logic [RW:0]   rel_inc;
  logic [RW-1:0] rel_sat;
  logic [PW:0]   press_inc;
  logic [PW-1:0] press_sat;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || !out_stall;
  assign in_stall  = stage_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      short_ticks   <= kpec_pkg::SHORT_RESET;
      long_ticks    <= kpec_pkg::LONG_RESET;
      repeat_ticks  <= kpec_pkg::REPEAT_RESET;
      release_start <= kpec_pkg::REL_START_RESET;
      release_end   <= kpec_pkg::REL_END_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (kpec_pkg::cfg_reg_t'(cfg_index))
        kpec_pkg::REG_SHORT:     short_ticks   <= cfg_data[kpec_pkg::SHORT_W-1:0];
        kpec_pkg::REG_LONG:      long_ticks    <= cfg_data;
        kpec_pkg::REG_REPEAT:    repeat_ticks  <= cfg_data;
        kpec_pkg::REG_REL_START: release_start <= cfg_data;
        kpec_pkg::REG_REL_END:   release_end   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    released = (stage_sample == kpec_pkg::KEY_NONE_LO) ||
               (stage_sample == kpec_pkg::KEY_NONE_HI);
    rel_inc   = (RW+1)'(release_count) + 1'b1;
    rel_sat   = (rel_inc > (RW+1)'(COUNT_LIMIT)) ? RW'(COUNT_LIMIT) : rel_inc[RW-1:0];
    press_inc = (PW+1)'(press_count) + 1'b1;
    press_sat = (press_inc > (PW+1)'(COUNT_LIMIT)) ? PW'(COUNT_LIMIT) : press_inc[PW-1:0];

    press_count_next     = press_count;
    release_count_next   = release_count;
    press_latched_next   = press_latched;
    previous_sample_next = previous_sample;
    remembered_key_next  = remembered_key;
    early = 1'b0;
    emit  = 1'b0;
    kind  = kpec_pkg::KIND_SHORT_DOWN;
    key   = stage_sample;

    if (released) begin
      release_count_next = rel_sat;
      if (rel_sat < RW'(release_start)) begin
        early = 1'b1;
      end else if (rel_sat < RW'(release_end)) begin
        priority if (press_count >= PW'(long_ticks)) begin
          emit = 1'b1;
          kind = kpec_pkg::KIND_LONG_UP;
          key  = remembered_key;
          press_latched_next = 1'b0;
        end else if (press_count >= PW'(short_ticks)) begin
          emit = 1'b1;
          kind = kpec_pkg::KIND_SHORT_UP;
          key  = remembered_key;
          press_latched_next = 1'b0;
        end else begin
          emit = 1'b0;
        end
        press_count_next    = '0;
        release_count_next  = kpec_pkg::UP_DONE;
        remembered_key_next = '0;
      end else begin
        press_latched_next = 1'b0;
        press_count_next   = '0;
        release_count_next = kpec_pkg::UP_DONE;
      end
    end else begin
      release_count_next = '0;
      press_count_next   = press_sat;
      priority if (press_sat == PW'(short_ticks)) begin
        emit = 1'b1;
        kind = kpec_pkg::KIND_SHORT_DOWN;
        press_latched_next  = 1'b1;
        remembered_key_next = stage_sample;
      end else if (press_sat == PW'(long_ticks)) begin
        emit = 1'b1;
        kind = kpec_pkg::KIND_LONG_DOWN;
        remembered_key_next = stage_sample;
      end else if (press_sat == PW'(repeat_ticks)) begin
        emit = 1'b1;
        kind = kpec_pkg::KIND_HOLD;
        press_count_next    = PW'(long_ticks);
        remembered_key_next = stage_sample;
      end else begin
        emit = 1'b0;
      end
    end

    // key change restarts the counters unless a press is latched or the release is still in its debounce span
    if (!early && (stage_sample != previous_sample) && !press_latched_next) begin
      previous_sample_next = stage_sample;
      press_count_next     = '0;
      release_count_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid     <= 1'b0;
      out_valid       <= 1'b0;
      press_count     <= '0;
      release_count   <= '0;
      press_latched   <= 1'b0;
      previous_sample <= '0;
      remembered_key  <= '0;
    end else begin
      if (!stage_valid || advance) begin
        stage_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= stage_valid && emit;
      end
      if (stage_valid && advance) begin
        press_count     <= press_count_next;
        release_count   <= release_count_next;
        press_latched   <= press_latched_next;
        previous_sample <= previous_sample_next;
        remembered_key  <= remembered_key_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      stage_sample <= key_sample;
    end
    if (advance && stage_valid && emit) begin
      event_kind <= kind;
      event_key  <= key;
    end
  end

endmodule

// ===== rtl/kpec_checker.sv =====
// port checker for the key press event classifier and its bind
`include "assert_macros.svh"

module kpec_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [kpec_pkg::KIND_W-1:0]    event_kind,
  input logic [kpec_pkg::KEY_W-1:0]     event_key
);

  // a stalled event holds its payload
  `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(event_kind) && $stable(event_key))

  // input back-pressure only comes from a stalled event
  `ASSERT_IMPL(a_stall_cause, in_stall, out_valid && out_stall)

  // no event straight after reset
  `ASSERT_ALWAYS(a_reset_quiet, ($past(rst) && !rst) |-> !out_valid)

  // a free output never pushes back on the input
  `ASSERT_IMPL(a_free_flow, !out_valid, !in_stall)

endmodule

bind key_press_event_classifier_unit kpec_checker u_kpec_checker (.*);

// ===== tb/sv/key_event_checker.sv =====
// checker for the key press event classifier: predicts events per scan tick and compares them
`timescale 1ns / 100ps
module key_event_checker #(
  parameter int unsigned COUNT_LIMIT = 500
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [kpec_pkg::KEY_W-1:0]     key_sample,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [kpec_pkg::KIND_W-1:0]    event_kind,
  input  logic [kpec_pkg::KEY_W-1:0]     event_key,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [kpec_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kpec_pkg::TICK_W-1:0]    cfg_data,
  output int                             fail_count,
  output int                             pending
);

  typedef struct packed {
    kpec_pkg::event_kind_t      kind;
    logic [kpec_pkg::KEY_W-1:0] key;
  } key_event_t;

  key_event_t expected_events[$];

  logic [kpec_pkg::SHORT_W-1:0] short_thr;
  logic [kpec_pkg::TICK_W-1:0]  long_thr;
  logic [kpec_pkg::TICK_W-1:0]  repeat_thr;
  logic [kpec_pkg::TICK_W-1:0]  rel_start;
  logic [kpec_pkg::TICK_W-1:0]  rel_end;

  int unsigned                press_cnt;
  int unsigned                release_cnt;
  bit                         latched;
  logic [kpec_pkg::KEY_W-1:0] last_sample;
  logic [kpec_pkg::KEY_W-1:0] held_key;

  function automatic int unsigned bump(input int unsigned v);
    return (v + 1 > COUNT_LIMIT) ? COUNT_LIMIT : v + 1;
  endfunction

  task automatic classify_tick(input logic [kpec_pkg::KEY_W-1:0] sample);
    key_event_t  ev;
    bit          emit;
    int unsigned n;
    emit = 1'b0;
    ev.kind = kpec_pkg::KIND_SHORT_DOWN;
    ev.key = '0;
    if (sample == kpec_pkg::KEY_NONE_LO || sample == kpec_pkg::KEY_NONE_HI) begin
      n = bump(release_cnt);
      release_cnt = n;
      // still inside the debounce span of the release
      if (n < rel_start) return;
      if (n < rel_end) begin
        if (press_cnt >= long_thr) begin
          emit = 1'b1;
          ev.kind = kpec_pkg::KIND_LONG_UP;
          ev.key = held_key;
          latched = 1'b0;
        end else if (press_cnt >= short_thr) begin
          emit = 1'b1;
          ev.kind = kpec_pkg::KIND_SHORT_UP;
          ev.key = held_key;
          latched = 1'b0;
        end
        press_cnt = 0;
        release_cnt = 32'(kpec_pkg::UP_DONE);
        held_key = '0;
      end else begin
        latched = 1'b0;
        press_cnt = 0;
        release_cnt = 32'(kpec_pkg::UP_DONE);
      end
    end else begin
      n = bump(press_cnt);
      release_cnt = 0;
      press_cnt = n;
      if (n == short_thr) begin
        emit = 1'b1;
        ev.kind = kpec_pkg::KIND_SHORT_DOWN;
        ev.key = sample;
        latched = 1'b1;
        held_key = sample;
      end else if (n == long_thr) begin
        emit = 1'b1;
        ev.kind = kpec_pkg::KIND_LONG_DOWN;
        ev.key = sample;
        held_key = sample;
      end else if (n == repeat_thr) begin
        press_cnt = 32'(long_thr);
        emit = 1'b1;
        ev.kind = kpec_pkg::KIND_HOLD;
        ev.key = sample;
        held_key = sample;
      end
    end
    // new key code with no press latched restarts both counters
    if (sample != last_sample && !latched) begin
      last_sample = sample;
      press_cnt = 0;
      release_cnt = 0;
    end
    if (emit) expected_events.push_back(ev);
  endtask

  always @(posedge clk) begin : watch_channels
    key_event_t want;
    if (rst) begin
      expected_events.delete();
      fail_count = 0;
      short_thr = kpec_pkg::SHORT_RESET;
      long_thr = kpec_pkg::LONG_RESET;
      repeat_thr = kpec_pkg::REPEAT_RESET;
      rel_start = kpec_pkg::REL_START_RESET;
      rel_end = kpec_pkg::REL_END_RESET;
      press_cnt = 0;
      release_cnt = 0;
      latched = 1'b0;
      last_sample = '0;
      held_key = '0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_events.size() == 0) begin
          $error("event transfer with nothing expected: event_kind %0d event_key %0d",
                 event_kind, event_key);
          fail_count++;
        end else begin
          want = expected_events.pop_front();
          if (event_kind !== want.kind) begin
            $error("event_kind mismatch: expected %0d, actual %0d", want.kind, event_kind);
            fail_count++;
          end
          if (event_key !== want.key) begin
            $error("event_key mismatch: expected %0d, actual %0d", want.key, event_key);
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          kpec_pkg::REG_SHORT:     short_thr = cfg_data[kpec_pkg::SHORT_W-1:0];
          kpec_pkg::REG_LONG:      long_thr = cfg_data;
          kpec_pkg::REG_REPEAT:    repeat_thr = cfg_data;
          kpec_pkg::REG_REL_START: rel_start = cfg_data;
          kpec_pkg::REG_REL_END:   rel_end = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) classify_tick(key_sample);
    end
    pending <= expected_events.size();
  end

endmodule

// ===== tb/sv/key_press_event_classifier_unit_tb.sv =====
// testbench top for the key press event classifier: stimulus, flow control and verdict
`timescale 1ns / 100ps
module key_press_event_classifier_unit_tb;

  localparam int unsigned KW = kpec_pkg::KEY_W;
  localparam int unsigned TW = kpec_pkg::TICK_W;
  localparam int unsigned SW = kpec_pkg::SHORT_W;

  localparam int LIMIT_CYCLES    = 600000;
  localparam int DRAIN_CYCLES    = 8;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam logic [kpec_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  logic                           clk;
  logic                           rst;
  logic                           in_valid;
  logic                           in_stall;
  logic [kpec_pkg::KEY_W-1:0]     key_sample;
  logic                           out_valid;
  logic                           out_stall;
  logic [kpec_pkg::KIND_W-1:0]    event_kind;
  logic [kpec_pkg::KEY_W-1:0]     event_key;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [kpec_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [kpec_pkg::TICK_W-1:0]    cfg_data;

  int fail_count;
  int pending;
  int cycles;
  int ticks_sent;
  bit hold_off_req;
  bit steady_sender;

  key_press_event_classifier_unit dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .key_sample (key_sample),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .event_kind (event_kind),
    .event_key  (event_key),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  key_event_checker chk (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .key_sample (key_sample),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .event_kind (event_kind),
    .event_key  (event_key),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // receiver: random stall runs, one long hold-off on request
  initial begin : receiver
    int  run;
    int  pick;
    bit  stalling;
    bit  held;
    out_stall = 1'b0;
    run = 0;
    stalling = 1'b0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        run = 0;
      end else begin
        if (run == 0) begin
          pick = $urandom_range(0, 99);
          if (pick < 45) begin
            stalling = 1'b0;
            run = $urandom_range(1, 40);
          end else if (pick < 90) begin
            stalling = 1'b1;
            run = $urandom_range(1, 3);
          end else begin
            stalling = 1'b1;
            run = $urandom_range(8, 40);
          end
        end
        out_stall <= stalling;
        run--;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_tick(input logic [kpec_pkg::KEY_W-1:0] k);
    int gap;
    in_valid <= 1'b1;
    key_sample <= k;
    do @(posedge clk); while (in_stall);
    ticks_sent++;
    gap = steady_sender ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_run(input logic [kpec_pkg::KEY_W-1:0] k, input int n);
    repeat (n) send_tick(k);
  endtask

  task automatic send_release(input int n);
    repeat (n) send_tick($urandom_range(0, 1) ? kpec_pkg::KEY_NONE_HI : kpec_pkg::KEY_NONE_LO);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [kpec_pkg::CFG_IDX_W-1:0] idx,
                           input logic [kpec_pkg::TICK_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_config(input logic [kpec_pkg::SHORT_W-1:0] s,
                            input logic [kpec_pkg::TICK_W-1:0] l,
                            input logic [kpec_pkg::TICK_W-1:0] r,
                            input logic [kpec_pkg::TICK_W-1:0] st,
                            input logic [kpec_pkg::TICK_W-1:0] en);
    wait_idle();
    write_reg(kpec_pkg::REG_SHORT, TW'(s));
    write_reg(kpec_pkg::REG_LONG, l);
    write_reg(kpec_pkg::REG_REPEAT, r);
    write_reg(kpec_pkg::REG_REL_START, st);
    write_reg(kpec_pkg::REG_REL_END, en);
    // unmapped index must leave every threshold alone
    write_reg(REG_SPARE, TW'($urandom_range(0, 511)));
    cfg_valid <= 1'b0;
    steady_sender = ($urandom_range(0, 3) == 0);
  endtask

  task automatic run_random(input int quota, input int press_max, input int release_max);
    int                         start;
    int                         mode;
    logic [kpec_pkg::KEY_W-1:0] k;
    start = ticks_sent;
    while (ticks_sent - start < quota) begin
      mode = $urandom_range(0, 99);
      k = KW'($urandom_range(1, 254));
      if (mode < 70) begin
        send_run(k, $urandom_range(0, press_max));
        send_release($urandom_range(0, release_max));
      end else if (mode < 85) begin
        // bounce or key change in the middle of a press
        send_run(k, $urandom_range(1, press_max));
        if ($urandom_range(0, 1)) send_release($urandom_range(1, 2));
        else send_tick(KW'($urandom_range(1, 254)));
        send_run(k, $urandom_range(0, press_max));
        send_release($urandom_range(0, release_max));
      end else begin
        repeat ($urandom_range(1, 8)) send_tick(KW'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    key_sample = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    hold_off_req = 1'b0;
    steady_sender = 1'b0;
    ticks_sent = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // smallest thresholds: every event kind within a few ticks
    set_config(8'd1, 9'd2, 9'd3, 9'd1, 9'd2);
    send_run(8'h01, 5);
    send_tick(kpec_pkg::KEY_NONE_LO);
    send_tick(kpec_pkg::KEY_NONE_LO);
    send_tick(8'hFE);
    send_tick(kpec_pkg::KEY_NONE_HI);
    send_tick(8'h80);
    send_run(8'h7F, 2);
    send_run(kpec_pkg::KEY_NONE_HI, 2);
    send_tick(8'hAA);
    send_tick(8'h55);
    send_release(3);
    send_run(8'hFE, 3);
    send_release(2);

    set_config(8'd3, 9'd8, 9'd12, 9'd2, 9'd5);
    // long hold-off with the sender pushing back to back
    steady_sender = 1'b1;
    hold_off_req <= 1'b1;
    send_run(8'h3C, 6);
    send_release(3);
    run_random(40, 16, 8);
    steady_sender = 1'b0;
    run_random(80, 16, 8);

    repeat (3) begin
      set_config(SW'($urandom_range(1, 6)), TW'($urandom_range(2, 15)),
                 TW'($urandom_range(3, 20)), TW'($urandom_range(1, 6)),
                 TW'($urandom_range(2, 10)));
      run_random(50, 22, 12);
    end

    // hold rewinds the press count to 499, just under the limit, so the press count saturates
    set_config(8'd2, 9'd499, 9'd4, 9'd1, 9'd500);
    run_random(60, 12, 6);

    set_config(8'd255, 9'd499, 9'd499, 9'd1, 9'd2);
    send_run(8'hC3, 503);
    send_release(3);

    set_config(kpec_pkg::SHORT_RESET, kpec_pkg::LONG_RESET, kpec_pkg::REPEAT_RESET,
               kpec_pkg::REL_START_RESET, kpec_pkg::REL_END_RESET);
    send_run(8'h5A, 12);
    send_release(20);
    send_run(8'hA5, 225);
    send_release(22);

    wait_idle();
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
